/* hdl/atrk_pkg.sv */
// Shared constants, types and state encodings for the abundant-number tracker.
package atrk_pkg;

  localparam int NUMBER_BITS = 16;
  localparam int TOP_DEPTH   = 3;

  localparam int NUM_W   = 16;
  localparam int SUM_W   = 18;
  localparam int COUNT_W = 32;
  localparam int SLOTS   = 3;

  // front-end queue between classification and the divisor search
  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // divisor candidate runs up to the square root of the number
  localparam int D_W   = (NUMBER_BITS + 1) / 2 + 1;
  localparam int SQ_W  = 2 * D_W;
  localparam int ACC_W = NUMBER_BITS + 4;
  localparam int CNT_W = $clog2(NUMBER_BITS);
  localparam int RANK_W = (TOP_DEPTH > 1) ? $clog2(TOP_DEPTH) : 1;

  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // queue entry from the front end
  typedef struct packed {
    logic [NUMBER_BITS-1:0] number;
    logic                   trivial;  // zero or one: no divisor search
  } atrk_item_t;

  // finished divisor sum handed to the ranking stage
  typedef struct packed {
    logic [NUMBER_BITS-1:0] number;
    logic [ACC_W-1:0]       exact;
  } atrk_result_t;

  typedef enum logic [2:0] {
    DS_IDLE,
    DS_CHK,
    DS_DIV,
    DS_ACC,
    DS_DONE
  } atrk_ds_state_t;

endpackage

/* hdl/atrk_front.sv */
// Front end: accepts numbers, classifies trivial ones, and queues them.
module atrk_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [15:0]          in_number,
  output logic                 q_valid,
  input  logic                 q_pop,
  output atrk_pkg::atrk_item_t q_item
);
  import atrk_pkg::*;

  atrk_item_t             mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]     wr_ptr_r;
  logic [Q_PTR_W-1:0]     rd_ptr_r;
  logic [Q_CNT_W-1:0]     count_r;
  logic                   push;
  logic                   pop;
  logic [NUMBER_BITS-1:0] masked;
  atrk_item_t             wr_item;

  always_comb begin
    masked = NUMBER_BITS'({{NUMBER_BITS{1'b0}}, in_number});
    wr_item.number  = masked;
    wr_item.trivial = (masked < NUMBER_BITS'(2));
  end

  assign in_stall = (count_r == Q_CNT_W'(Q_DEPTH));
  assign q_valid  = (count_r != '0);
  assign push     = in_valid && !in_stall;
  assign pop      = q_pop && q_valid;
  assign q_item   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + Q_PTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + Q_CNT_W'(1);
        2'b01:   count_r <= count_r - Q_CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

/* hdl/atrk_divsum.sv */
// Back end: aliquot sum by divisor pairs, one shared restoring divider.
module atrk_divsum (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  output logic                   q_pop,
  input  atrk_pkg::atrk_item_t   q_item,
  output logic                   res_valid,
  input  logic                   res_ready,
  output atrk_pkg::atrk_result_t res
);
  import atrk_pkg::*;

  atrk_ds_state_t         state_r, state_nxt;
  logic [NUMBER_BITS-1:0] n_r, n_nxt;
  logic [D_W-1:0]         d_r, d_nxt;
  logic [SQ_W-1:0]        sq_r, sq_nxt;
  logic [ACC_W-1:0]       acc_r, acc_nxt;
  logic [NUMBER_BITS-1:0] rem_r, rem_nxt;
  logic [NUMBER_BITS-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;

  logic [NUMBER_BITS:0]   rem_sh;
  logic [NUMBER_BITS:0]   d_ext;
  logic [NUMBER_BITS:0]   rem_sub;
  logic                   fits;
  logic [NUMBER_BITS:0]   d_cmp;
  logic [ACC_W-1:0]       add_d;
  logic [ACC_W-1:0]       add_q;

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    d_nxt     = d_r;
    sq_nxt    = sq_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    cnt_nxt   = cnt_r;
    q_pop     = 1'b0;
    res_valid = 1'b0;

    d_ext   = (NUMBER_BITS + 1)'(d_r);
    rem_sh  = {rem_r, quo_r[NUMBER_BITS-1]};
    fits    = (rem_sh >= d_ext);
    rem_sub = rem_sh - d_ext;
    d_cmp   = d_ext;
    add_d   = ((NUMBER_BITS + 1)'(n_r) > d_cmp) ? ACC_W'(d_r) : '0;
    add_q   = ((quo_r != NUMBER_BITS'(d_r)) && (quo_r < n_r)) ? ACC_W'(quo_r) : '0;

    unique case (state_r)
      DS_IDLE: begin
        q_pop = q_valid;
        if (q_valid) begin
          n_nxt     = q_item.number;
          d_nxt     = D_W'(1);
          sq_nxt    = SQ_W'(1);
          acc_nxt   = '0;
          state_nxt = q_item.trivial ? DS_DONE : DS_CHK;
        end
      end
      DS_CHK: begin
        if (sq_r > SQ_W'(n_r)) begin
          state_nxt = DS_DONE;
        end else begin
          rem_nxt   = '0;
          quo_nxt   = n_r;
          cnt_nxt   = CNT_W'(NUMBER_BITS - 1);
          state_nxt = DS_DIV;
        end
      end
      DS_DIV: begin
        // one quotient bit per cycle, MSB first
        rem_nxt = fits ? rem_sub[NUMBER_BITS-1:0] : rem_sh[NUMBER_BITS-1:0];
        quo_nxt = {quo_r[NUMBER_BITS-2:0], fits};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) state_nxt = DS_ACC;
      end
      DS_ACC: begin
        if (rem_r == '0) acc_nxt = acc_r + add_d + add_q;
        // (d+1)^2 = d^2 + 2d + 1
        sq_nxt    = sq_r + SQ_W'({d_r, 1'b0}) + SQ_W'(1);
        d_nxt     = d_r + D_W'(1);
        state_nxt = DS_CHK;
      end
      DS_DONE: begin
        res_valid = 1'b1;
        if (res_ready) state_nxt = DS_IDLE;
      end
      default: state_nxt = DS_IDLE;
    endcase
  end

  assign res.number = n_r;
  assign res.exact  = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    d_r   <= d_nxt;
    sq_r  <= sq_nxt;
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    cnt_r <= cnt_nxt;
  end

endmodule

/* hdl/atrk_rank.sv */
// Ranking stage: abundance test, saturating count, top list and output register.
module atrk_rank (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   res_valid,
  output logic                   res_ready,
  input  atrk_pkg::atrk_result_t res,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [17:0]            out_aliquot_sum,
  output logic                   out_is_abundant,
  output logic [31:0]            out_abundant_count,
  output logic [15:0]            out_first_number,
  output logic [17:0]            out_first_sum,
  output logic [15:0]            out_second_number,
  output logic [17:0]            out_second_sum,
  output logic [15:0]            out_third_number,
  output logic [17:0]            out_third_sum
);
  import atrk_pkg::*;

  logic [NUMBER_BITS-1:0] rank_num_r [TOP_DEPTH];
  logic [SUM_W-1:0]       rank_sum_r [TOP_DEPTH];
  logic [NUMBER_BITS-1:0] rank_num_nxt [TOP_DEPTH];
  logic [SUM_W-1:0]       rank_sum_nxt [TOP_DEPTH];
  logic [COUNT_W-1:0]     total_r, total_nxt;
  logic                   out_valid_r;

  logic [SUM_W-1:0]       sum_sat;
  logic                   abundant;
  logic [TOP_DEPTH-1:0]   ge;
  logic                   load;

  logic [NUM_W-1:0]       slot_num [SLOTS];
  logic [SUM_W-1:0]       slot_sum [SLOTS];

  logic [SUM_W-1:0]       sum_out_r;
  logic                   abund_out_r;
  logic [NUM_W-1:0]       num_out_r [SLOTS];
  logic [SUM_W-1:0]       ssum_out_r [SLOTS];

  assign res_ready = !out_valid_r || !out_stall;
  assign load      = res_valid && res_ready;

  always_comb begin
    sum_sat  = (res.exact > ACC_W'(SUM_MAX)) ? SUM_MAX : res.exact[SUM_W-1:0];
    abundant = (res.exact > ACC_W'(res.number));
    total_nxt = total_r;
    if (abundant && (total_r != COUNT_MAX)) total_nxt = total_r + COUNT_W'(1);

    // list is sorted descending, so ge is monotone: the first set bit is
    // the insertion slot, everything from there shifts down by one
    for (int i = 0; i < TOP_DEPTH; i++) begin
      ge[i] = (sum_sat >= rank_sum_r[i]);
    end
    for (int i = 0; i < TOP_DEPTH; i++) begin
      rank_num_nxt[i] = rank_num_r[i];
      rank_sum_nxt[i] = rank_sum_r[i];
      if (abundant && ge[i]) begin
        if (i == 0) begin
          rank_num_nxt[i] = res.number;
          rank_sum_nxt[i] = sum_sat;
        end else if (!ge[i-1]) begin
          rank_num_nxt[i] = res.number;
          rank_sum_nxt[i] = sum_sat;
        end else begin
          rank_num_nxt[i] = rank_num_r[i-1];
          rank_sum_nxt[i] = rank_sum_r[i-1];
        end
      end
    end
  end

  for (genvar k = 0; k < SLOTS; k++) begin : g_slot
    if (k < TOP_DEPTH) begin : g_live
      assign slot_num[k] = NUM_W'(rank_num_nxt[k]);
      assign slot_sum[k] = rank_sum_nxt[k];
    end else begin : g_empty
      assign slot_num[k] = '0;
      assign slot_sum[k] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      total_r     <= '0;
      for (int i = 0; i < TOP_DEPTH; i++) begin
        rank_num_r[i] <= '0;
        rank_sum_r[i] <= '0;
      end
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        total_r     <= total_nxt;
        for (int i = 0; i < TOP_DEPTH; i++) begin
          rank_num_r[i] <= rank_num_nxt[i];
          rank_sum_r[i] <= rank_sum_nxt[i];
        end
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sum_out_r   <= sum_sat;
      abund_out_r <= abundant;
      for (int k = 0; k < SLOTS; k++) begin
        num_out_r[k]  <= slot_num[k];
        ssum_out_r[k] <= slot_sum[k];
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_aliquot_sum    = sum_out_r;
  assign out_is_abundant    = abund_out_r;
  assign out_abundant_count = total_r;
  assign out_first_number   = num_out_r[0];
  assign out_first_sum      = ssum_out_r[0];
  assign out_second_number  = num_out_r[1];
  assign out_second_sum     = ssum_out_r[1];
  assign out_third_number   = num_out_r[2];
  assign out_third_sum      = ssum_out_r[2];

endmodule

/* hdl/abundant_number_top3_tracker_top.sv */
// The divisor search takes one number at a time; for n it tries each candidate up to
//   floor(sqrt(n)) with a check, a restoring division and an add.
//   Zero and one skip the divisor search.
// Path: into the two-entry queue, through the divisor search, into the output register.
// A two-entry queue takes new numbers while the divisor search runs.
// Synchronous active-low reset clears the queue, the engine, the count and the top list.
module abundant_number_top3_tracker_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_number,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [17:0] out_aliquot_sum,
  output logic        out_is_abundant,
  output logic [31:0] out_abundant_count,
  output logic [15:0] out_first_number,
  output logic [17:0] out_first_sum,
  output logic [15:0] out_second_number,
  output logic [17:0] out_second_sum,
  output logic [15:0] out_third_number,
  output logic [17:0] out_third_sum
);
  import atrk_pkg::*;

  logic         q_valid;
  logic         q_pop;
  atrk_item_t   q_item;
  logic         res_valid;
  logic         res_ready;
  atrk_result_t res;

  atrk_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_number (in_number),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item)
  );

  atrk_divsum u_divsum (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  atrk_rank u_rank (
    .clk                (clk),
    .rst_n              (rst_n),
    .res_valid          (res_valid),
    .res_ready          (res_ready),
    .res                (res),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_aliquot_sum    (out_aliquot_sum),
    .out_is_abundant    (out_is_abundant),
    .out_abundant_count (out_abundant_count),
    .out_first_number   (out_first_number),
    .out_first_sum      (out_first_sum),
    .out_second_number  (out_second_number),
    .out_second_sum     (out_second_sum),
    .out_third_number   (out_third_number),
    .out_third_sum      (out_third_sum)
  );

endmodule

/* hdl/atrk_checker.sv */
// Port-level checker for the tracker and its bind to the top level.
module atrk_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [17:0] out_aliquot_sum,
  input logic        out_is_abundant,
  input logic [31:0] out_abundant_count,
  input logic [17:0] out_first_sum,
  input logic [17:0] out_second_sum,
  input logic [17:0] out_third_sum
);

  // a stalled result transfer holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_aliquot_sum)
      && $stable(out_abundant_count))
    else $error("result changed while stalled");

  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_first_sum >= out_second_sum) && (out_second_sum >= out_third_sum))
    else $error("top list out of order");

  // an abundant number is always placed at or below the leader and is counted
  a_leader: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_abundant |-> (out_first_sum >= out_aliquot_sum)
      && (out_abundant_count != 32'd0) && (out_aliquot_sum >= 18'd2))
    else $error("abundant result not reflected in list or count");

  // reset clears out_valid, so no result is flagged right after reset
  a_no_phantom: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result without transfer after reset");

endmodule

bind abundant_number_top3_tracker_top atrk_checker u_atrk_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_aliquot_sum    (out_aliquot_sum),
  .out_is_abundant    (out_is_abundant),
  .out_abundant_count (out_abundant_count),
  .out_first_sum      (out_first_sum),
  .out_second_sum     (out_second_sum),
  .out_third_sum      (out_third_sum)
);
